[rtl/cac_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cac_pkg
// Types, constants and the arctangent table for the connector alignment check.
// ----------------------------------------------------------------------------
package cac_pkg;

  localparam int CORDIC_STEPS_DEF  = 16;
  localparam int POS_FRAC_BITS_DEF = 16;

  // angle word, units of 2^-16 rad
  localparam int ZW = 20;
  localparam logic signed [ZW-1:0] ANG_PI      = 20'sd205887;
  localparam logic signed [ZW-1:0] ANG_HALF_PI = 20'sd102944;
  localparam logic signed [ZW-1:0] ANG_TWO_PI  = 20'sd411775;

  localparam logic [29:0] KINV_Q30       = 30'd652032874;
  localparam logic [14:0] ERR_MAX        = 15'd25736;
  localparam logic [15:0] IDLE_MILLIAMPS = 16'hF448;

  localparam int PADDR_W = 5;

  typedef enum logic [2:0] {
    REG_ROBOT_OFFSET   = 3'd0,
    REG_STATION_OFFSET = 3'd1,
    REG_DOCK_RADIUS    = 3'd2,
    REG_ANGLE_LIMIT    = 3'd3,
    REG_SUPPLY_MV      = 3'd4,
    REG_SUPPLY_MA      = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] robot_px;
    logic signed [31:0] robot_py;
    logic signed [15:0] robot_qx;
    logic signed [15:0] robot_qy;
    logic signed [15:0] robot_qz;
    logic signed [15:0] robot_qw;
    logic signed [31:0] station_px;
    logic signed [31:0] station_py;
    logic signed [15:0] station_qx;
    logic signed [15:0] station_qy;
    logic signed [15:0] station_qz;
    logic signed [15:0] station_qw;
  } in_req_t;

  typedef struct packed {
    logic               docked;
    logic [15:0]        out_millivolts;
    logic signed [15:0] out_milliamps;
    logic [14:0]        angle_error;
  } out_req_t;

  typedef struct packed {
    logic [15:0]        robot_offset;
    logic [15:0]        station_offset;
    logic [15:0]        dock_radius;
    logic [14:0]        angle_limit;
    logic [15:0]        supply_millivolts;
    logic signed [15:0] supply_milliamps;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] rpx;
    logic signed [31:0] rpy;
    logic signed [31:0] spx;
    logic signed [31:0] spy;
  } pos_t;

  // atan(2^-i) * 2^16, rounded
  function automatic logic signed [ZW-1:0] atan_lut(input int unsigned i);
    logic signed [ZW-1:0] v;
    case (i)
      0:       v = 20'sd51472;
      1:       v = 20'sd30386;
      2:       v = 20'sd16055;
      3:       v = 20'sd8150;
      4:       v = 20'sd4091;
      5:       v = 20'sd2047;
      6:       v = 20'sd1024;
      7:       v = 20'sd512;
      8:       v = 20'sd256;
      9:       v = 20'sd128;
      10:      v = 20'sd64;
      11:      v = 20'sd32;
      12:      v = 20'sd16;
      13:      v = 20'sd8;
      14:      v = 20'sd4;
      15:      v = 20'sd2;
      16:      v = 20'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[rtl/connector_alignment_check_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// connector_alignment_check_core
// Docking check: yaw from quaternions, connector placement, distance/angle test.
// ----------------------------------------------------------------------------
// Stages: two cell chains of CORDIC_STEPS each, plus six fixed stages, the
//   first loaded at the accepting edge.
// Throughput: one request per cycle; the whole pipe holds while a result stalls.
// Reset: clears all stage valids and loads the register defaults.
module connector_alignment_check_core #(
  parameter int CORDIC_STEPS  = cac_pkg::CORDIC_STEPS_DEF,
  parameter int POS_FRAC_BITS = cac_pkg::POS_FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  cac_pkg::in_req_t            in_req_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output cac_pkg::out_req_t           out_req_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cac_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import cac_pkg::*;

  localparam int N   = CORDIC_STEPS;
  localparam int P   = POS_FRAC_BITS;
  localparam int VW  = 36;
  localparam int RW  = 16 + P + 3;
  localparam int SH  = 30 - P;
  localparam int DW  = 35;
  localparam int AW  = 22;
  localparam logic [49:0]          OFS_RND = 50'(1) << (SH - 1);
  localparam logic signed [RW:0]   POS_RND = (RW+1)'(1) <<< (P - 1);
  localparam logic signed [AW-1:0] PI_A    = AW'(ANG_PI);
  localparam logic signed [AW-1:0] TWOPI_A = AW'(ANG_TWO_PI);

  cfg_t cfg;
  logic adv;

  cac_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // pipe moves unless the output holds an unread result
  logic out_v_q;
  assign adv        = !out_v_q || !out_stall_i;
  assign in_stall_o = !adv;

  // ---------------- stage 0: quaternion products, offset gain ----------------
  logic signed [15:0] qv [2][4];
  logic [15:0]        ofs [2];
  assign qv[0][0] = in_req_i.robot_qx;
  assign qv[0][1] = in_req_i.robot_qy;
  assign qv[0][2] = in_req_i.robot_qz;
  assign qv[0][3] = in_req_i.robot_qw;
  assign qv[1][0] = in_req_i.station_qx;
  assign qv[1][1] = in_req_i.station_qy;
  assign qv[1][2] = in_req_i.station_qz;
  assign qv[1][3] = in_req_i.station_qw;
  assign ofs[0]   = cfg.robot_offset;
  assign ofs[1]   = cfg.station_offset;

  logic               s0_v_q;
  pos_t               s0_pos_q;
  logic signed [31:0] s0_prod_q [2][6];
  logic [45:0]        s0_oprod_q [2];

  // ---------------- stage 1: atan2 arguments, quadrant fold ----------------
  logic                  s1_v_q;
  pos_t                  s1_pos_q;
  logic signed [VW-1:0]  s1_x_q [2];
  logic signed [VW-1:0]  s1_y_q [2];
  logic signed [ZW-1:0]  s1_z_q [2];
  logic                  s1_zero_q [2];
  logic signed [RW-1:0]  s1_r_q [2];

  // ---------------- chains ----------------
  logic signed [VW-1:0] vx_w [2][N+1];
  logic signed [VW-1:0] vy_w [2][N+1];
  logic signed [ZW-1:0] vz_w [2][N+1];
  logic signed [RW-1:0] rx_w [2][N+1];
  logic signed [RW-1:0] ry_w [2][N+1];
  logic signed [ZW-1:0] rz_w [2][N+1];

  logic [N-1:0]         vv_q;
  pos_t                 vpos_q [N];
  logic signed [RW-1:0] vr_q [N][2];
  logic                 vzero_q [N][2];

  logic                 s2_v_q;
  pos_t                 s2_pos_q;
  logic signed [RW-1:0] s2_x_q [2];
  logic signed [RW-1:0] s2_y_q [2];
  logic signed [ZW-1:0] s2_z_q [2];
  logic signed [ZW-1:0] s2_yaw_q [2];

  logic [N-1:0]         rv_q;
  pos_t                 rpos_q [N];
  logic signed [ZW-1:0] ryaw_q [N][2];

  for (genvar p = 0; p < 2; p++) begin : g_pose
    logic signed [33:0]   ny, nx;
    logic signed [VW-1:0] x1, y1;
    logic signed [ZW-1:0] z1;
    logic [49:0]          rt;
    logic signed [ZW-1:0] yaw, z2;
    logic signed [RW-1:0] r2, x2, y2;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        s0_prod_q[p][0] <= qv[p][3] * qv[p][2];
        s0_prod_q[p][1] <= qv[p][0] * qv[p][1];
        s0_prod_q[p][2] <= qv[p][3] * qv[p][3];
        s0_prod_q[p][3] <= qv[p][0] * qv[p][0];
        s0_prod_q[p][4] <= qv[p][1] * qv[p][1];
        s0_prod_q[p][5] <= qv[p][2] * qv[p][2];
        s0_oprod_q[p]   <= 46'(ofs[p]) * 46'(KINV_Q30);
      end
    end

    always_comb begin
      ny = (34'(s0_prod_q[p][0]) + 34'(s0_prod_q[p][1])) <<< 1;
      nx = 34'(s0_prod_q[p][2]) + 34'(s0_prod_q[p][3])
         - 34'(s0_prod_q[p][4]) - 34'(s0_prod_q[p][5]);
      x1 = VW'(nx);
      y1 = VW'(ny);
      z1 = '0;
      if (nx < 0) begin
        if (ny >= 0) begin
          x1 = VW'(ny);
          y1 = -VW'(nx);
          z1 = ANG_HALF_PI;
        end else begin
          x1 = -VW'(ny);
          y1 = VW'(nx);
          z1 = -ANG_HALF_PI;
        end
      end
      rt = {4'b0, s0_oprod_q[p]} + OFS_RND;
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        s1_x_q[p]    <= x1;
        s1_y_q[p]    <= y1;
        s1_z_q[p]    <= z1;
        s1_zero_q[p] <= (nx == 0) && (ny == 0);
        s1_r_q[p]    <= signed'(rt[SH +: RW]);
      end
    end

    assign vx_w[p][0] = s1_x_q[p];
    assign vy_w[p][0] = s1_y_q[p];
    assign vz_w[p][0] = s1_z_q[p];

    for (genvar k = 0; k < N; k++) begin : g_vcell
      cac_cordic_cell #(.W(VW), .STEP(k), .VEC(1'b1)) u_cell (
        .clk_i (clk_i),
        .en_i  (adv),
        .x_i   (vx_w[p][k]),
        .y_i   (vy_w[p][k]),
        .z_i   (vz_w[p][k]),
        .x_o   (vx_w[p][k+1]),
        .y_o   (vy_w[p][k+1]),
        .z_o   (vz_w[p][k+1])
      );
    end

    // yaw known; fold into rotation range
    always_comb begin
      yaw = vzero_q[N-1][p] ? '0 : vz_w[p][N];
      r2  = vr_q[N-1][p];
      x2  = r2;
      y2  = '0;
      z2  = yaw;
      if (yaw > ANG_HALF_PI) begin
        x2 = '0;
        y2 = r2;
        z2 = yaw - ANG_HALF_PI;
      end else if (yaw < -ANG_HALF_PI) begin
        x2 = '0;
        y2 = -r2;
        z2 = yaw + ANG_HALF_PI;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        s2_x_q[p]   <= x2;
        s2_y_q[p]   <= y2;
        s2_z_q[p]   <= z2;
        s2_yaw_q[p] <= yaw;
      end
    end

    assign rx_w[p][0] = s2_x_q[p];
    assign ry_w[p][0] = s2_y_q[p];
    assign rz_w[p][0] = s2_z_q[p];

    for (genvar k = 0; k < N; k++) begin : g_rcell
      cac_cordic_cell #(.W(RW), .STEP(k), .VEC(1'b0)) u_cell (
        .clk_i (clk_i),
        .en_i  (adv),
        .x_i   (rx_w[p][k]),
        .y_i   (ry_w[p][k]),
        .z_i   (rz_w[p][k]),
        .x_o   (rx_w[p][k+1]),
        .y_o   (ry_w[p][k+1]),
        .z_o   (rz_w[p][k+1])
      );
    end
  end

  // sideband riding along the chains
  for (genvar k = 0; k < N; k++) begin : g_side
    if (k == 0) begin : g_head
      always_ff @(posedge clk_i) begin
        if (adv) begin
          vpos_q[k]     <= s1_pos_q;
          vr_q[k][0]    <= s1_r_q[0];
          vr_q[k][1]    <= s1_r_q[1];
          vzero_q[k][0] <= s1_zero_q[0];
          vzero_q[k][1] <= s1_zero_q[1];
          rpos_q[k]     <= s2_pos_q;
          ryaw_q[k][0]  <= s2_yaw_q[0];
          ryaw_q[k][1]  <= s2_yaw_q[1];
        end
      end
    end else begin : g_body
      always_ff @(posedge clk_i) begin
        if (adv) begin
          vpos_q[k]     <= vpos_q[k-1];
          vr_q[k][0]    <= vr_q[k-1][0];
          vr_q[k][1]    <= vr_q[k-1][1];
          vzero_q[k][0] <= vzero_q[k-1][0];
          vzero_q[k][1] <= vzero_q[k-1][1];
          rpos_q[k]     <= rpos_q[k-1];
          ryaw_q[k][0]  <= ryaw_q[k-1][0];
          ryaw_q[k][1]  <= ryaw_q[k-1][1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_pos_q.rpx <= in_req_i.robot_px;
      s0_pos_q.rpy <= in_req_i.robot_py;
      s0_pos_q.spx <= in_req_i.station_px;
      s0_pos_q.spy <= in_req_i.station_py;
      s1_pos_q     <= s0_pos_q;
      s2_pos_q     <= vpos_q[N-1];
    end
  end

  // ---------------- stage 3: connector offsets, heading wrap ----------------
  logic signed [DW-1:0] cx [2];
  logic signed [DW-1:0] cy [2];
  logic signed [DW-1:0] dx, dy;
  logic signed [AW-1:0] dang;
  logic [17:0]          dabs;

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      cx[p] = DW'(((RW+1)'(rx_w[p][N]) + POS_RND) >>> P);
      cy[p] = DW'(((RW+1)'(ry_w[p][N]) + POS_RND) >>> P);
    end
    dx = DW'(rpos_q[N-1].spx) - DW'(rpos_q[N-1].rpx) + cx[1] - cx[0];
    dy = DW'(rpos_q[N-1].spy) - DW'(rpos_q[N-1].rpy) + cy[1] - cy[0];
    dang = AW'(ryaw_q[N-1][1]) - AW'(ryaw_q[N-1][0]) + PI_A;
    // yaw span keeps this within two turns either way
    for (int i = 0; i < 2; i++) begin
      if (dang > PI_A) dang = dang - TWOPI_A;
    end
    for (int i = 0; i < 2; i++) begin
      if (dang <= -PI_A) dang = dang + TWOPI_A;
    end
    dabs = dang[AW-1] ? 18'(-dang) : 18'(dang);
  end

  logic                 s3_v_q;
  logic signed [DW-1:0] s3_dx_q, s3_dy_q;
  logic [17:0]          s3_dabs_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_dx_q   <= dx;
      s3_dy_q   <= dy;
      s3_dabs_q <= dabs;
    end
  end

  // ---------------- stage 4: squares, angle error ----------------
  logic [DW-1:0] ax, ay;
  logic [17:0]   e;
  logic [15:0]   err_full;
  logic [14:0]   err;

  always_comb begin
    ax       = s3_dx_q[DW-1] ? DW'(-s3_dx_q) : DW'(s3_dx_q);
    ay       = s3_dy_q[DW-1] ? DW'(-s3_dy_q) : DW'(s3_dy_q);
    e        = 18'(ANG_PI) - s3_dabs_q;
    err_full = 16'((19'(e) + 19'd4) >> 3);
    err      = (err_full > 16'(ERR_MAX)) ? ERR_MAX : err_full[14:0];
  end

  logic        s4_v_q;
  logic [63:0] s4_sqx_q, s4_sqy_q;
  logic        s4_sat_q;
  logic [14:0] s4_err_q;
  logic [31:0] s4_rad2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_sqx_q  <= ax[31:0] * ax[31:0];
      s4_sqy_q  <= ay[31:0] * ay[31:0];
      s4_sat_q  <= (|ax[DW-1:32]) || (|ay[DW-1:32]);
      s4_err_q  <= err;
      s4_rad2_q <= 32'(cfg.dock_radius) * 32'(cfg.dock_radius);
    end
  end

  // ---------------- output register ----------------
  logic [64:0] dsum;
  logic        dock;
  out_req_t    out_d, out_q;

  always_comb begin
    dsum = 65'(s4_sqx_q) + 65'(s4_sqy_q);
    dock = !s4_sat_q && !dsum[64] && (dsum[63:0] < 64'(s4_rad2_q))
        && (s4_err_q < cfg.angle_limit);
    out_d.docked         = dock;
    out_d.out_millivolts = dock ? cfg.supply_millivolts : 16'd0;
    out_d.out_milliamps  = dock ? cfg.supply_milliamps : signed'(IDLE_MILLIAMPS);
    out_d.angle_error    = s4_err_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      vv_q    <= '0;
      s2_v_q  <= 1'b0;
      rv_q    <= '0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      s0_v_q  <= in_valid_i;
      s1_v_q  <= s0_v_q;
      vv_q    <= {vv_q[N-2:0], s1_v_q};
      s2_v_q  <= vv_q[N-1];
      rv_q    <= {rv_q[N-2:0], s2_v_q};
      s3_v_q  <= rv_q[N-1];
      s4_v_q  <= s3_v_q;
      out_v_q <= s4_v_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_req_o   = out_q;

  // ---------------- assertions ----------------
  a_idle_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_q.docked |->
      out_q.out_milliamps == signed'(IDLE_MILLIAMPS) && out_q.out_millivolts == 16'd0)
    else $error("undocked result carries supply values");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vv_q) && $stable(rv_q) && $stable(out_q))
    else $error("pipe moved while output stalled");

  a_err_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> out_q.angle_error <= ERR_MAX)
    else $error("angle error above clamp");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> !(out_v_q && out_stall_i))
    else $error("request taken while result stalled");

endmodule

[rtl/cac_cordic_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cac_cordic_cell
// One CORDIC micro-rotation with its output register; vectoring or rotation.
// ----------------------------------------------------------------------------
module cac_cordic_cell #(
  parameter int W    = 36,
  parameter int STEP = 0,
  parameter bit VEC  = 1'b1
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [W-1:0]          x_i,
  input  logic signed [W-1:0]          y_i,
  input  logic signed [cac_pkg::ZW-1:0] z_i,
  output logic signed [W-1:0]          x_o,
  output logic signed [W-1:0]          y_o,
  output logic signed [cac_pkg::ZW-1:0] z_o
);
  import cac_pkg::*;

  localparam logic signed [ZW-1:0] ATAN = atan_lut(STEP);

  logic signed [W-1:0]  xs, ys, x_d, y_d, x_q, y_q;
  logic signed [ZW-1:0] z_d, z_q;
  logic                 cw;

  assign xs = x_i >>> STEP;
  assign ys = y_i >>> STEP;
  // vectoring drives y to zero, rotation drives z to zero
  assign cw = VEC ? !y_i[W-1] : z_i[ZW-1];

  always_comb begin
    if (cw) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + ATAN;
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - ATAN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

[rtl/cac_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cac_cfg_regs
// APB register file holding offsets, limits and supply values.
// ----------------------------------------------------------------------------
module cac_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cac_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output cac_pkg::cfg_t               cfg_o
);
  import cac_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr;

  assign idx    = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (idx)
        REG_ROBOT_OFFSET:   cfg_d.robot_offset      = pwdata[15:0];
        REG_STATION_OFFSET: cfg_d.station_offset    = pwdata[15:0];
        REG_DOCK_RADIUS:    cfg_d.dock_radius       = pwdata[15:0];
        REG_ANGLE_LIMIT:    cfg_d.angle_limit       = pwdata[14:0];
        REG_SUPPLY_MV:      cfg_d.supply_millivolts = pwdata[15:0];
        REG_SUPPLY_MA:      cfg_d.supply_milliamps  = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ROBOT_OFFSET:   prdata = {16'b0, cfg_q.robot_offset};
      REG_STATION_OFFSET: prdata = {16'b0, cfg_q.station_offset};
      REG_DOCK_RADIUS:    prdata = {16'b0, cfg_q.dock_radius};
      REG_ANGLE_LIMIT:    prdata = {17'b0, cfg_q.angle_limit};
      REG_SUPPLY_MV:      prdata = {16'b0, cfg_q.supply_millivolts};
      REG_SUPPLY_MA:      prdata = {16'b0, cfg_q.supply_milliamps};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.robot_offset      <= 16'd11796;
      cfg_q.station_offset    <= 16'd14418;
      cfg_q.dock_radius       <= 16'd1966;
      cfg_q.angle_limit       <= 15'd4096;
      cfg_q.supply_millivolts <= 16'd30000;
      cfg_q.supply_milliamps  <= 16'sd5000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
